[hdl/cfc_pkg.sv]
// shared types, constants and the crc byte update for the frame checker
package cfc_pkg;

  localparam int unsigned MaxFrameLenDef = 256;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [6:0]  BaseMinLen   = 7'd8;
  localparam logic [15:0] FrameOvhd    = 16'd8;
  localparam logic [7:0]  WantVersion  = 8'h01;
  localparam logic [15:0] BcastId      = 16'hFFFF;
  localparam logic [15:0] BcastCrc     = 16'h63FA;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] OwnIdReset   = 16'h0002;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinLen  = 3'd0,
    CfgGetId   = 3'd1,
    CfgSetId   = 3'd2,
    CfgSingle  = 3'd3,
    CfgStart   = 3'd4,
    CfgStop    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StLenErr   = 3'd2,
    StVerErr   = 3'd3,
    StTypeErr  = 3'd4,
    StCrcErr   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActReport  = 3'd1,
    ActSetOk   = 3'd2,
    ActSetFail = 3'd3,
    ActSample  = 3'd4,
    ActStart   = 3'd5,
    ActStop    = 3'd6
  } action_e;

  typedef struct packed {
    logic [6:0] min_len;
    logic [7:0] get_id;
    logic [7:0] set_id;
    logic [7:0] single;
    logic [7:0] start;
    logic [7:0] stop;
  } cfg_t;

  // header and crc state of one finished frame
  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] tail;
    logic [15:0] id;
    logic [7:0]  ftype;
    logic [15:0] length;
    logic [7:0]  version;
    logic [15:0] word;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    action_e     action;
    logic [15:0] rx_device_id;
    logic [7:0]  frame_type;
    logic [7:0]  frame_version;
    logic [15:0] payload_len;
    logic [15:0] payload_word;
    logic [15:0] own_id;
    logic        sampling_on;
  } res_t;

  // crc16 modbus, one byte, reflected
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hdl/cfc_if.sv]
// valid/ready channels for received bytes and frame results
interface cfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface cfc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  action;
  logic [15:0] rx_device_id;
  logic [7:0]  frame_type;
  logic [7:0]  frame_version;
  logic [15:0] payload_len;
  logic [15:0] payload_word;
  logic [15:0] own_id;
  logic        sampling_on;

  modport source (output valid, output status, output action, output rx_device_id,
                  output frame_type, output frame_version, output payload_len,
                  output payload_word, output own_id, output sampling_on, input ready);
  modport sink   (input valid, input status, input action, input rx_device_id,
                  input frame_type, input frame_version, input payload_len,
                  input payload_word, input own_id, input sampling_on, output ready);
endinterface

[hdl/cfc_frame_acc.sv]
// per-beat crc, byte count and header capture, with the finished-frame register
module cfc_frame_acc #(
  parameter int unsigned CntCap = 257,
  parameter int unsigned CntW   = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             last_byte_i,
  output cfc_pkg::hdr_t    hdr_o,
  output logic [CntW-1:0]  cnt_o
);
  import cfc_pkg::*;

  hdr_t            run_q, run_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  hdr_t            sum_q;
  logic [CntW-1:0] sum_cnt_q;

  always_comb begin
    run_d = run_q;
    // crc trails the stream by two bytes so the crc field stays out
    if (cnt_q >= CntW'(2)) begin
      run_d.crc = crc_feed(run_q.crc, run_q.tail[15:8]);
    end
    run_d.tail = {run_q.tail[7:0], rx_byte_i};
    if (cnt_q == CntW'(0)) run_d.id[15:8]     = rx_byte_i;
    if (cnt_q == CntW'(1)) run_d.id[7:0]      = rx_byte_i;
    if (cnt_q == CntW'(2)) run_d.ftype        = rx_byte_i;
    if (cnt_q == CntW'(3)) run_d.length[15:8] = rx_byte_i;
    if (cnt_q == CntW'(4)) run_d.length[7:0]  = rx_byte_i;
    if (cnt_q == CntW'(5)) run_d.version      = rx_byte_i;
    if (cnt_q == CntW'(6)) run_d.word[15:8]   = rx_byte_i;
    if (cnt_q == CntW'(7)) run_d.word[7:0]    = rx_byte_i;
    // saturate: beyond the cap the frame is too long whatever the exact count
    cnt_d = (cnt_q == CntW'(CntCap)) ? cnt_q : cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '{crc: CrcInit, default: '0};
      cnt_q <= '0;
    end else if (beat_i) begin
      if (last_byte_i) begin
        run_q <= '{crc: CrcInit, default: '0};
        cnt_q <= '0;
      end else begin
        run_q <= run_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && last_byte_i) begin
      sum_q     <= run_d;
      sum_cnt_q <= cnt_d;
    end
  end

  assign hdr_o = sum_q;
  assign cnt_o = sum_cnt_q;

endmodule

[hdl/cfc_frame_eval.sv]
// frame checks, command dispatch, stored id and sampling flag, result register
module cfc_frame_eval #(
  parameter int unsigned MaxFrameLen = 256,
  parameter int unsigned CntW        = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cfc_pkg::cfg_t    cfg_i,
  input  cfc_pkg::hdr_t    hdr_i,
  input  logic [CntW-1:0]  cnt_i,
  output cfc_pkg::res_t    res_o
);
  import cfc_pkg::*;

  localparam int unsigned TooLong = (MaxFrameLen + 1 < 65535) ? MaxFrameLen + 1 : 65535;

  logic [15:0] own_id_q, own_id_d;
  logic        samp_q, samp_d;
  res_t        res_q, res_d;

  logic [16:0] cnt_x;
  logic [6:0]  eff_min;
  logic        known, crc_ok, bcast;
  logic        is_get, is_set, is_single, is_start, is_stop;
  logic [15:0] plen;

  always_comb begin
    cnt_x     = 17'(cnt_i);
    eff_min   = (cfg_i.min_len < BaseMinLen) ? BaseMinLen : cfg_i.min_len;
    is_get    = hdr_i.ftype == cfg_i.get_id;
    is_set    = hdr_i.ftype == cfg_i.set_id;
    is_single = hdr_i.ftype == cfg_i.single;
    is_start  = hdr_i.ftype == cfg_i.start;
    is_stop   = hdr_i.ftype == cfg_i.stop;
    known     = is_get || is_set || is_single || is_start || is_stop;
    crc_ok    = hdr_i.crc == hdr_i.tail;
    // broadcast id request with a fixed crc is let through
    bcast     = (hdr_i.id == BcastId) && is_get && (hdr_i.length == 16'(eff_min))
                && (hdr_i.tail == BcastCrc);
    plen      = 16'(cnt_i) - FrameOvhd;

    own_id_d = own_id_q;
    samp_d   = samp_q;
    res_d    = '0;

    if (cnt_x < 17'(eff_min)) begin
      res_d.status = StShort;
    end else if (cnt_x >= 17'(TooLong) || hdr_i.length != 16'(cnt_i)) begin
      res_d.status = StLenErr;
    end else if (hdr_i.version != WantVersion) begin
      res_d.status = StVerErr;
    end else if (!known) begin
      res_d.status = StTypeErr;
    end else if (!crc_ok && !bcast) begin
      res_d.status = StCrcErr;
    end else begin
      res_d.status = StOk;
    end

    if (res_d.status == StOk) begin
      res_d.payload_len = crc_ok ? plen : 16'd0;
      if (res_d.payload_len >= 16'd2) res_d.payload_word = hdr_i.word;
      if (is_get) begin
        res_d.action = ActReport;
      end else if (is_set) begin
        if (res_d.payload_len == 16'd2) begin
          own_id_d     = hdr_i.word;
          res_d.action = ActSetOk;
        end else begin
          res_d.action = ActSetFail;
        end
      end else if (is_single) begin
        res_d.action = ActSample;
      end else if (is_start) begin
        samp_d       = 1'b1;
        res_d.action = ActStart;
      end else begin
        samp_d       = 1'b0;
        res_d.action = ActStop;
      end
    end

    if (res_d.status != StShort) begin
      res_d.rx_device_id  = hdr_i.id;
      res_d.frame_type    = hdr_i.ftype;
      res_d.frame_version = hdr_i.version;
    end
    res_d.own_id      = own_id_d;
    res_d.sampling_on = samp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= OwnIdReset;
      samp_q   <= 1'b0;
    end else if (load_i) begin
      own_id_q <= own_id_d;
      samp_q   <= samp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[hdl/crc16_frame_checker_dispatch_unit.sv]
// top level: crc16 modbus frame checker and command dispatcher
// one byte beat accepted per cycle unless a finished frame is held by result back-pressure,
// no gaps needed between frames; a frame's result passes the finished-frame register and then the result register
// non-final beats give no result; one result per frame, in frame order
// reset (async, active low) clears the frame state, stored id to 0x0002,
// sampling flag off and all config registers to their defaults
module crc16_frame_checker_dispatch_unit #(
  parameter int unsigned MAX_FRAME_LEN = cfc_pkg::MaxFrameLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cfc_rx_if.sink                        rx_i,
  cfc_res_if.source                     res_o
);
  import cfc_pkg::*;

  localparam int unsigned CntBase = (MAX_FRAME_LEN > 64) ? MAX_FRAME_LEN : 64;
  localparam int unsigned CntCap  = (CntBase + 1 < 65535) ? CntBase + 1 : 65535;
  localparam int unsigned CntW    = $clog2(CntCap + 1);

  cfg_t            cfg_q;
  logic            sum_v_q, res_v_q;
  logic            beat, sum_go;
  hdr_t            hdr;
  logic [CntW-1:0] cnt;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_len: 7'd8, get_id: 8'd1, set_id: 8'd2,
                 single: 8'd3, start: 8'd4, stop: 8'd5};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinLen: cfg_q.min_len <= cfg_wdata_i[6:0];
        CfgGetId:  cfg_q.get_id  <= cfg_wdata_i;
        CfgSetId:  cfg_q.set_id  <= cfg_wdata_i;
        CfgSingle: cfg_q.single  <= cfg_wdata_i;
        CfgStart:  cfg_q.start   <= cfg_wdata_i;
        CfgStop:   cfg_q.stop    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // finished frame moves on when the result register is free or drains
  assign sum_go     = !res_v_q || res_o.ready;
  assign rx_i.ready = !sum_v_q || sum_go;
  assign beat       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (beat && rx_i.last_byte) begin
        sum_v_q <= 1'b1;
      end else if (sum_go) begin
        sum_v_q <= 1'b0;
      end
      if (sum_v_q && sum_go) begin
        res_v_q <= 1'b1;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  cfc_frame_acc #(
    .CntCap (CntCap),
    .CntW   (CntW)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (rx_i.rx_byte),
    .last_byte_i (rx_i.last_byte),
    .hdr_o       (hdr),
    .cnt_o       (cnt)
  );

  cfc_frame_eval #(
    .MaxFrameLen (MAX_FRAME_LEN),
    .CntW        (CntW)
  ) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (sum_v_q && sum_go),
    .cfg_i  (cfg_q),
    .hdr_i  (hdr),
    .cnt_i  (cnt),
    .res_o  (res)
  );

  assign res_o.valid         = res_v_q;
  assign res_o.status        = res.status;
  assign res_o.action        = res.action;
  assign res_o.rx_device_id  = res.rx_device_id;
  assign res_o.frame_type    = res.frame_type;
  assign res_o.frame_version = res.frame_version;
  assign res_o.payload_len   = res.payload_len;
  assign res_o.payload_word  = res.payload_word;
  assign res_o.own_id        = res.own_id;
  assign res_o.sampling_on   = res.sampling_on;

endmodule

[hdl/cfc_checker.sv]
// port-level checks on the result channel, bound to the top level
module cfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  status_i,
  input logic [2:0]  action_i,
  input logic [15:0] rx_device_id_i,
  input logic [7:0]  frame_type_i,
  input logic [7:0]  frame_version_i,
  input logic [15:0] payload_len_i,
  input logic [15:0] payload_word_i,
  input logic [15:0] own_id_i
);
  import cfc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i) && $stable(own_id_i))
    else $error("result beat changed while stalled");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != StOk |-> action_i == ActNone && payload_len_i == 16'd0)
    else $error("rejected frame carries an action or payload");

  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == StShort
      |-> rx_device_id_i == 16'd0 && frame_type_i == 8'd0 && frame_version_i == 8'd0)
    else $error("short frame reports header fields");

  a_ok_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == StOk |-> action_i != ActNone)
    else $error("accepted frame without action");

  a_set_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && action_i == ActSetOk
      |-> own_id_i == payload_word_i && payload_len_i == 16'd2)
    else $error("set id not reflected in own id");

endmodule

bind crc16_frame_checker_dispatch_unit cfc_checker u_cfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .status_i        (res_o.status),
  .action_i        (res_o.action),
  .rx_device_id_i  (res_o.rx_device_id),
  .frame_type_i    (res_o.frame_type),
  .frame_version_i (res_o.frame_version),
  .payload_len_i   (res_o.payload_len),
  .payload_word_i  (res_o.payload_word),
  .own_id_i        (res_o.own_id)
);
